[design/ddt_pkg.sv]
// Shared types and constants for the dataflow dependency depth tracker.
package ddt_pkg;

    localparam int DEF_NUM_REGS    = 32;
    localparam int DEF_NUM_OPCODES = 32;
    localparam int DEF_MAX_INSTS   = 1024;

    localparam int REG_W   = 5;
    localparam int OPC_W   = 5;
    localparam int LAT_W   = 8;
    localparam int IDX_W   = 10;
    localparam int DEP_W   = 11;
    localparam int DEPTH_W = 18;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [DEP_W-1:0]   NO_DEP    = {DEP_W{1'b1}};

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_INST = 1'b1;

    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    typedef struct packed {
        logic             req_type;
        logic [OPC_W-1:0] opcode;
        logic [LAT_W-1:0] latency_value;
        logic [REG_W-1:0] dst_reg;
        logic [REG_W-1:0] src_first_reg;
        logic [REG_W-1:0] src_second_reg;
        logic             new_program;
    } ddt_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   inst_index;
        logic [DEP_W-1:0]   dep_first;
        logic [DEP_W-1:0]   dep_second;
        logic [DEPTH_W-1:0] inst_depth;
        logic [DEPTH_W-1:0] program_depth;
        logic               overflow;
    } ddt_res_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic             is_inst;
        logic             new_program;
        logic             opc_ok;
        logic [OPC_W-1:0] opcode;
        logic [LAT_W-1:0] latency_value;
        logic             dst_ok;
        logic [REG_W-1:0] dst_reg;
        logic             src1_ok;
        logic [REG_W-1:0] src_first_reg;
        logic             src2_ok;
        logic [REG_W-1:0] src_second_reg;
    } ddt_cmd_t;

endpackage

[design/dataflow_dependency_depth_tracker.sv]
// Top level of the dataflow dependency depth tracker.
//
// Input queue side: drive a request word on req and raise push; the word is
// taken at a rising edge with push high and full low. A word with req_type
// low loads one opcode latency and returns nothing; an instruction word
// returns exactly one result word.
// Result queue side: while empty is low the oldest result is on res; it is
// taken at a rising edge with pop high.
// Throughput is one word per cycle while the result queue has room. An
// instruction word passes through the classify register, the command queue
// and the table stage, whose registered reads and table update set the pace;
// its result then enters the result queue and shows on res. When pop is held
// low the result queue fills, the table stage holds, then the command queue
// and finally full rises; nothing is dropped.
// Reset clears all queues, the latency and writer tables (through per-entry
// valid bits), the instruction index and the program depth at once; the block
// takes words in the first cycle after reset.
module dataflow_dependency_depth_tracker import ddt_pkg::*; #(
    parameter int NUM_REGS    = DEF_NUM_REGS,
    parameter int NUM_OPCODES = DEF_NUM_OPCODES,
    parameter int MAX_INSTS   = DEF_MAX_INSTS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ddt_req_t req,
    output logic     full,
    input  logic     pop,
    output ddt_res_t res,
    output logic     empty
);

    logic     cmd_push;
    ddt_cmd_t cmd_in;
    logic     cmdq_full;
    logic     cmdq_empty;
    ddt_cmd_t cmd_head;
    logic     cmd_pop;
    logic     res_push;
    ddt_res_t res_in;
    logic     resq_full;

    ddt_front #(
        .NUM_REGS    (NUM_REGS),
        .NUM_OPCODES (NUM_OPCODES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req       (req),
        .full      (full),
        .cmd_valid (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmdq_full)
    );

    ddt_fifo #(
        .WIDTH ($bits(ddt_cmd_t)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmdq_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (cmdq_empty)
    );

    ddt_exec #(
        .NUM_REGS    (NUM_REGS),
        .NUM_OPCODES (NUM_OPCODES),
        .MAX_INSTS   (MAX_INSTS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmdq_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (resq_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    ddt_fifo #(
        .WIDTH ($bits(ddt_res_t)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (resq_full),
        .pop   (pop),
        .dout  (res),
        .empty (empty)
    );

    a_cmd_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_push && cmdq_full))
        else $error("command queue written while full");

    a_cmd_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_pop && cmdq_empty))
        else $error("command queue read while empty");

    a_res_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_push && resq_full))
        else $error("result queue written while full");

endmodule

[design/ddt_fifo.sv]
// Small synchronous queue used between the front, the back and the result port.
module ddt_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

[design/ddt_front.sv]
// Front stage: accepts request words and classifies them into commands.
module ddt_front import ddt_pkg::*; #(
    parameter int NUM_REGS    = DEF_NUM_REGS,
    parameter int NUM_OPCODES = DEF_NUM_OPCODES
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ddt_req_t req,
    output logic     full,
    output logic     cmd_valid,
    output ddt_cmd_t cmd,
    input  logic     cmd_full
);

    logic     valid_reg;
    ddt_cmd_t cmd_reg;
    ddt_cmd_t cmd_next;
    logic     accept;

    assign full      = valid_reg && cmd_full;
    assign accept    = push && !full;
    assign cmd_valid = valid_reg && !cmd_full;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next.is_inst        = (req.req_type == REQ_INST);
        cmd_next.new_program    = req.new_program;
        cmd_next.opc_ok         = (int'(req.opcode) < NUM_OPCODES);
        cmd_next.opcode         = req.opcode;
        cmd_next.latency_value  = req.latency_value;
        cmd_next.dst_ok         = (int'(req.dst_reg) < NUM_REGS);
        cmd_next.dst_reg        = req.dst_reg;
        cmd_next.src1_ok        = (int'(req.src_first_reg) < NUM_REGS);
        cmd_next.src_first_reg  = req.src_first_reg;
        cmd_next.src2_ok        = (int'(req.src_second_reg) < NUM_REGS);
        cmd_next.src_second_reg = req.src_second_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd_valid)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[design/ddt_exec.sv]
// Back stage: latency and last-writer tables, depth computation and result build.
module ddt_exec import ddt_pkg::*; #(
    parameter int NUM_REGS    = DEF_NUM_REGS,
    parameter int NUM_OPCODES = DEF_NUM_OPCODES,
    parameter int MAX_INSTS   = DEF_MAX_INSTS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_empty,
    input  ddt_cmd_t cmd,
    output logic     cmd_pop,
    input  logic     res_full,
    output logic     res_push,
    output ddt_res_t res
);

    localparam int RA_W = $clog2(NUM_REGS);
    localparam int OA_W = $clog2(NUM_OPCODES);
    localparam int WI_W = $clog2(MAX_INSTS);
    localparam int NI_W = $clog2(MAX_INSTS + 1);
    localparam logic [NI_W-1:0] MAX_CNT  = NI_W'(MAX_INSTS);
    localparam logic [WI_W-1:0] LAST_IDX = WI_W'(MAX_INSTS - 1);

    logic [LAT_W-1:0]   lat_mem  [NUM_OPCODES];
    logic [WI_W-1:0]    widx_mem [NUM_REGS];
    logic [DEPTH_W-1:0] wfin_mem [NUM_REGS];

    logic [NUM_OPCODES-1:0] lat_valid_reg;
    logic [NUM_REGS-1:0]    writer_valid_reg;
    logic [NUM_REGS-1:0]    writer_valid_next;
    logic [NI_W-1:0]        next_index_reg;
    logic [DEPTH_W-1:0]     longest_reg;

    logic               b_valid_reg;
    ddt_cmd_t           b_cmd_reg;
    logic [LAT_W-1:0]   lat_rd_reg;
    logic [WI_W-1:0]    idx1_rd_reg;
    logic [WI_W-1:0]    idx2_rd_reg;
    logic [DEPTH_W-1:0] fin1_rd_reg;
    logic [DEPTH_W-1:0] fin2_rd_reg;

    logic [OA_W-1:0] h_opc, b_opc;
    logic [RA_W-1:0] h_s1, h_s2, b_s1, b_s2, b_dst;

    logic                b_fire;
    logic [NUM_REGS-1:0] valid_eff;
    logic                hit1, hit2;
    logic [DEPTH_W-1:0]  fin1, fin2, depth, finish, lp_eff, lp_new;
    logic [DEP_W-1:0]    dep1, dep2;
    logic [LAT_W-1:0]    lat;
    logic [DEPTH_W:0]    sum;
    logic                sat;
    logic [NI_W-1:0]     next_eff;
    logic                is_full;
    logic [WI_W-1:0]     idx;
    logic                wr_writer, wr_lat;

    assign h_opc = OA_W'(cmd.opcode);
    assign h_s1  = RA_W'(cmd.src_first_reg);
    assign h_s2  = RA_W'(cmd.src_second_reg);
    assign b_opc = OA_W'(b_cmd_reg.opcode);
    assign b_s1  = RA_W'(b_cmd_reg.src_first_reg);
    assign b_s2  = RA_W'(b_cmd_reg.src_second_reg);
    assign b_dst = RA_W'(b_cmd_reg.dst_reg);

    assign b_fire  = b_valid_reg && (!b_cmd_reg.is_inst || !res_full);
    assign cmd_pop = !cmd_empty && (!b_valid_reg || b_fire);

    // A new program drops every writer before this instruction looks them up.
    assign valid_eff = b_cmd_reg.new_program ? '0 : writer_valid_reg;
    assign next_eff  = b_cmd_reg.new_program ? '0 : next_index_reg;
    assign lp_eff    = b_cmd_reg.new_program ? '0 : longest_reg;

    assign hit1  = b_cmd_reg.src1_ok && valid_eff[b_s1];
    assign hit2  = b_cmd_reg.src2_ok && valid_eff[b_s2];
    assign fin1  = hit1 ? fin1_rd_reg : '0;
    assign fin2  = hit2 ? fin2_rd_reg : '0;
    assign dep1  = hit1 ? DEP_W'(idx1_rd_reg) : NO_DEP;
    assign dep2  = hit2 ? DEP_W'(idx2_rd_reg) : NO_DEP;
    assign depth = (fin1 > fin2) ? fin1 : fin2;

    assign lat    = (b_cmd_reg.opc_ok && lat_valid_reg[b_opc]) ? lat_rd_reg : '0;
    assign sum    = {1'b0, depth} + (DEPTH_W + 1)'(lat);
    assign sat    = sum[DEPTH_W];
    assign finish = sat ? DEPTH_MAX : sum[DEPTH_W-1:0];

    assign is_full = (next_eff >= MAX_CNT);
    assign idx     = is_full ? LAST_IDX : WI_W'(next_eff);
    assign lp_new  = (!is_full && (finish > lp_eff)) ? finish : lp_eff;

    assign wr_writer = b_fire && b_cmd_reg.is_inst && !is_full && b_cmd_reg.dst_ok;
    assign wr_lat    = b_fire && !b_cmd_reg.is_inst && b_cmd_reg.opc_ok;

    always_comb
    begin
        writer_valid_next = valid_eff;
        if (!is_full && b_cmd_reg.dst_ok)
        begin
            writer_valid_next[b_dst] = 1'b1;
        end
    end

    assign res_push          = b_fire && b_cmd_reg.is_inst;
    assign res.inst_index    = IDX_W'(idx);
    assign res.dep_first     = dep1;
    assign res.dep_second    = dep2;
    assign res.inst_depth    = depth;
    assign res.program_depth = lp_new;
    assign res.overflow      = sat || is_full;

    // Table writes from the back stage.
    always_ff @(posedge clk)
    begin
        if (wr_lat)
        begin
            lat_mem[b_opc] <= b_cmd_reg.latency_value;
        end
        if (wr_writer)
        begin
            widx_mem[b_dst] <= idx;
            wfin_mem[b_dst] <= finish;
        end
    end

    // Registered table reads for the word leaving the queue; forward this cycle's write.
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            b_cmd_reg   <= cmd;
            lat_rd_reg  <= (wr_lat && (b_opc == h_opc)) ? b_cmd_reg.latency_value
                                                        : lat_mem[h_opc];
            idx1_rd_reg <= (wr_writer && (b_dst == h_s1)) ? idx : widx_mem[h_s1];
            fin1_rd_reg <= (wr_writer && (b_dst == h_s1)) ? finish : wfin_mem[h_s1];
            idx2_rd_reg <= (wr_writer && (b_dst == h_s2)) ? idx : widx_mem[h_s2];
            fin2_rd_reg <= (wr_writer && (b_dst == h_s2)) ? finish : wfin_mem[h_s2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg      <= 1'b0;
            lat_valid_reg    <= '0;
            writer_valid_reg <= '0;
            next_index_reg   <= '0;
            longest_reg      <= '0;
        end
        else
        begin
            if (cmd_pop)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (wr_lat)
            begin
                lat_valid_reg[b_opc] <= 1'b1;
            end
            if (b_fire && b_cmd_reg.is_inst)
            begin
                writer_valid_reg <= writer_valid_next;
                next_index_reg   <= is_full ? next_eff : next_eff + NI_W'(1);
                longest_reg      <= lp_new;
            end
        end
    end

endmodule
